### src/pedt_pkg.sv
// shared constants and types for the parabola envelope distance transform
package pedt_pkg;

    localparam int IN_W  = 32;
    localparam int OUT_W = 32;

    // boundary numerators are signed integers with a fixed width
    localparam int NUM_W = 48;
    localparam logic signed [NUM_W-1:0] INF_NUM = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [NUM_W-1:0] NEG_INF_NUM = -INF_NUM;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISECT,
        S_MUL,
        S_CMP,
        S_OSTART,
        S_OFIRST,
        S_OFETCH,
        S_OEVAL
    } t_state;

endpackage

### src/pedt_if.sv
// request channel interfaces for samples in and distances out
interface pedt_in_if import pedt_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] height;
    logic            line_end;

    modport source (output valid, output height, output line_end, input ready);
    modport sink   (input valid, input height, input line_end, output ready);
endinterface

interface pedt_out_if import pedt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] distance_sq;
    logic             run_end;

    modport source (output valid, output distance_sq, output run_end, input ready);
    modport sink   (input valid, input distance_sq, input run_end, output ready);
endinterface

### src/parabola_envelope_distance_transform_core.sv
// 1d squared distance transform over a line of parabola heights (lower envelope)
//
//   port     dir  request payload
//   i_in     in   height[31:0], line_end
//   o_out    out  distance_sq[31:0], run_end
//
// a line's first sample is written straight to the envelope; any other sample runs
// one read / intersect / cross-multiply / compare round on the envelope memory for each
// popped entry plus a final one; pops total at most one per sample over a line
// after the last sample S_OSTART, S_OFIRST and S_OFETCH prime the walk, then it gives
// one result per cycle while o_out is free; each boundary crossed re-reads the read port
// synchronous active-low reset clears control only; the envelope memory is never cleared
// o_out stalls hold the walk; the final result sits in the output register while the
// next line is already being accepted
module parabola_envelope_distance_transform_core import pedt_pkg::*; #(
    parameter int MAX_LINE    = 64,
    parameter int HEIGHT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pedt_in_if.sink     i_in,
    pedt_out_if.source  o_out
);

    localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int HB = HEIGHT_BITS;
    localparam int DW = AW + 1;
    localparam int PW = NUM_W + DW + 1;
    localparam int SW = ((HB > 2 * AW) ? HB : 2 * AW) + 1;
    localparam int EW = AW + HB + NUM_W + DW;
    localparam logic [HB-1:0] HMASK = {HB{1'b1}};
    localparam logic [AW-1:0] LAST_POS = AW'(MAX_LINE - 1);

    // envelope memory: {vertex, height, boundary numer, boundary denom}
    // the boundary of entry k lies below vertex k
    logic [EW-1:0] r_env_mem [MAX_LINE];
    logic [EW-1:0] r_rdata;

    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;

    t_state r_state, n_state;

    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_top, n_top;
    logic [AW-1:0] r_k, n_k;
    logic [AW-1:0] r_p, n_p;
    logic          r_nxt_ok, n_nxt_ok;
    logic          r_out_valid, n_out_valid;

    logic [HB-1:0] r_f, n_f;
    logic          r_end, n_end;
    logic signed [NUM_W-1:0] r_num, n_num;
    logic [DW-1:0]           r_den, n_den;
    logic signed [NUM_W-1:0] r_bn, n_bn;
    logic [DW-1:0]           r_bd, n_bd;
    logic signed [PW-1:0]    r_lhs, n_lhs;
    logic signed [PW-1:0]    r_rhs, n_rhs;

    logic [AW-1:0]           r_cur_v, n_cur_v;
    logic [HB-1:0]           r_cur_f, n_cur_f;
    logic [AW-1:0]           r_nxt_v, n_nxt_v;
    logic [HB-1:0]           r_nxt_f, n_nxt_f;
    logic signed [NUM_W-1:0] r_nxt_bn, n_nxt_bn;
    logic [DW-1:0]           r_nxt_bd, n_nxt_bd;
    logic [OUT_W-1:0]        r_out_dist, n_out_dist;
    logic                    r_out_end, n_out_end;

    // read data fields
    logic [AW-1:0]           rd_v;
    logic [HB-1:0]           rd_f;
    logic signed [NUM_W-1:0] rd_bn;
    logic [DW-1:0]           rd_bd;

    assign rd_bd = r_rdata[DW-1:0];
    assign rd_bn = $signed(r_rdata[DW+NUM_W-1:DW]);
    assign rd_f  = r_rdata[DW+NUM_W+HB-1:DW+NUM_W];
    assign rd_v  = r_rdata[EW-1:DW+NUM_W+HB];

    logic          in_fire;
    logic [HB-1:0] f_in;
    logic          end_in;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign f_in       = HB'(i_in.height);
    assign end_in     = i_in.line_end || (r_pos == LAST_POS);

    // intersection of the new parabola with the one read from the envelope
    logic                    iq, iv;
    logic [2*AW-1:0]         qsq, vsq;
    logic [NUM_W-1:0]        q_term, v_term;
    logic signed [NUM_W-1:0] isect_num;
    logic [DW-1:0]           isect_den;

    assign iq     = (r_f == HMASK);
    assign iv     = (rd_f == HMASK);
    assign qsq    = (2 * AW)'(r_pos) * (2 * AW)'(r_pos);
    assign vsq    = (2 * AW)'(rd_v) * (2 * AW)'(rd_v);
    assign q_term = NUM_W'(r_f) + NUM_W'(qsq);
    assign v_term = NUM_W'(rd_f) + NUM_W'(vsq);

    always_comb begin
        if (iq && iv) begin
            isect_num = '0;
            isect_den = {r_pos - rd_v, 1'b0};
        end else if (iq) begin
            isect_num = INF_NUM;
            isect_den = DW'(1);
        end else if (iv) begin
            isect_num = NEG_INF_NUM;
            isect_den = DW'(1);
        end else begin
            isect_num = $signed(q_term - v_term);
            isect_den = {r_pos - rd_v, 1'b0};
        end
    end

    // pop while the new intersection is at or below the top boundary
    logic pop;
    assign pop = (r_k != '0) && (r_lhs <= r_rhs);

    // output walk: step to the next vertex while its boundary lies below p
    logic [AW+DW-1:0]        p_bd;
    logic signed [NUM_W-1:0] p_bd_s;
    logic                    adv;
    logic                    out_free;
    logic [AW:0]             k_plus2;

    assign p_bd     = (AW + DW)'(r_p) * (AW + DW)'(r_nxt_bd);
    assign p_bd_s   = $signed(NUM_W'(p_bd));
    assign adv      = r_nxt_ok && (r_nxt_bn < p_bd_s);
    assign out_free = !r_out_valid || o_out.ready;
    assign k_plus2  = {1'b0, r_k} + (AW + 1)'(2);

    logic [AW-1:0]   gap;
    logic [2*AW-1:0] gap_sq;
    logic [SW-1:0]   sum;
    logic [HB-1:0]   res;

    assign gap    = (r_p >= r_cur_v) ? (r_p - r_cur_v) : (r_cur_v - r_p);
    assign gap_sq = (2 * AW)'(gap) * (2 * AW)'(gap);
    assign sum    = SW'(gap_sq) + SW'(r_cur_f);
    assign res    = ((r_cur_f == HMASK) || (sum > SW'(HMASK))) ? HMASK : sum[HB-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (r_pos == '0) begin
                        n_state = end_in ? S_OSTART : S_IDLE;
                    end else begin
                        n_state = S_ISECT;
                    end
                end
            end
            S_ISECT:  n_state = S_MUL;
            S_MUL:    n_state = S_CMP;
            S_CMP: begin
                if (pop) begin
                    n_state = S_ISECT;
                end else begin
                    n_state = r_end ? S_OSTART : S_IDLE;
                end
            end
            S_OSTART: n_state = S_OFIRST;
            S_OFIRST: n_state = S_OFETCH;
            S_OFETCH: n_state = S_OEVAL;
            S_OEVAL: begin
                if (adv) begin
                    n_state = S_OFETCH;
                end else if (out_free && (r_p == r_pos)) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_pos       = r_pos;
        n_top       = r_top;
        n_k         = r_k;
        n_p         = r_p;
        n_nxt_ok    = r_nxt_ok;
        n_f         = r_f;
        n_end       = r_end;
        n_num       = r_num;
        n_den       = r_den;
        n_bn        = r_bn;
        n_bd        = r_bd;
        n_lhs       = r_lhs;
        n_rhs       = r_rhs;
        n_cur_v     = r_cur_v;
        n_cur_f     = r_cur_f;
        n_nxt_v     = r_nxt_v;
        n_nxt_f     = r_nxt_f;
        n_nxt_bn    = r_nxt_bn;
        n_nxt_bd    = r_nxt_bd;
        n_out_dist  = r_out_dist;
        n_out_end   = r_out_end;
        n_out_valid = r_out_valid && !o_out.ready;
        mem_re      = 1'b0;
        mem_raddr   = r_k;
        mem_we      = 1'b0;
        mem_waddr   = r_k;
        mem_wdata   = '0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_f   = f_in;
                    n_end = end_in;
                    if (r_pos == '0) begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = {{AW{1'b0}}, f_in, NEG_INF_NUM, DW'(1)};
                        n_top     = '0;
                        if (!end_in) begin
                            n_pos = r_pos + AW'(1);
                        end
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_top;
                        n_k       = r_top;
                    end
                end
            end
            S_ISECT: begin
                n_num = isect_num;
                n_den = isect_den;
                n_bn  = rd_bn;
                n_bd  = rd_bd;
            end
            S_MUL: begin
                n_lhs = PW'(r_num) * PW'($signed({1'b0, r_bd}));
                n_rhs = PW'(r_bn) * PW'($signed({1'b0, r_den}));
            end
            S_CMP: begin
                if (pop) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_k - AW'(1);
                    n_k       = r_k - AW'(1);
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_k + AW'(1);
                    mem_wdata = {r_pos, r_f, r_num, r_den};
                    n_top     = r_k + AW'(1);
                    if (!r_end) begin
                        n_pos = r_pos + AW'(1);
                    end
                end
            end
            S_OSTART: begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                n_k       = '0;
                n_p       = '0;
            end
            S_OFIRST: begin
                n_cur_v = rd_v;
                n_cur_f = rd_f;
                if (r_top != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(1);
                end
            end
            S_OFETCH: begin
                n_nxt_v  = rd_v;
                n_nxt_f  = rd_f;
                n_nxt_bn = rd_bn;
                n_nxt_bd = rd_bd;
                n_nxt_ok = (r_k < r_top);
            end
            S_OEVAL: begin
                if (adv) begin
                    n_cur_v = r_nxt_v;
                    n_cur_f = r_nxt_f;
                    n_k     = r_k + AW'(1);
                    if ((r_k + AW'(1)) < r_top) begin
                        mem_re    = 1'b1;
                        mem_raddr = k_plus2[AW-1:0];
                    end
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_dist  = OUT_W'(res);
                    n_out_end   = (r_p == r_pos);
                    if (r_p == r_pos) begin
                        n_pos = '0;
                        n_top = '0;
                    end else begin
                        n_p = r_p + AW'(1);
                    end
                end
            end
            default: begin
                n_out_valid = r_out_valid && !o_out.ready;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_top       <= '0;
            r_k         <= '0;
            r_p         <= '0;
            r_nxt_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_top       <= n_top;
            r_k         <= n_k;
            r_p         <= n_p;
            r_nxt_ok    <= n_nxt_ok;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_f        <= n_f;
        r_end      <= n_end;
        r_num      <= n_num;
        r_den      <= n_den;
        r_bn       <= n_bn;
        r_bd       <= n_bd;
        r_lhs      <= n_lhs;
        r_rhs      <= n_rhs;
        r_cur_v    <= n_cur_v;
        r_cur_f    <= n_cur_f;
        r_nxt_v    <= n_nxt_v;
        r_nxt_f    <= n_nxt_f;
        r_nxt_bn   <= n_nxt_bn;
        r_nxt_bd   <= n_nxt_bd;
        r_out_dist <= n_out_dist;
        r_out_end  <= n_out_end;
    end

    // envelope memory, one write and one registered read per cycle
    // reads and writes never target the same entry in one cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_env_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_env_mem[mem_raddr];
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.distance_sq = r_out_dist;
    assign o_out.run_end     = r_out_end;

    // envelope never holds more entries than samples seen
    a_top_below_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_pos != '0) |-> (r_top < r_pos))
        else $error("envelope top not below line position");

    a_pop_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISECT) |-> (r_k <= r_top))
        else $error("pop index beyond envelope top");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OEVAL) |-> (r_k <= r_top && r_p <= r_pos))
        else $error("output walk beyond envelope or line");

    a_line_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OEVAL && n_state == S_IDLE) |=>
            (r_pos == '0 && r_out_valid && r_out_end))
        else $error("line closed without final result");

endmodule

### tb/tb.sv
// testbench for the parabola envelope distance transform core: self-checking random lines
module tb;
    import pedt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LINE_CAP   = 64;
    localparam logic [31:0] HEIGHT_INF = 32'hFFFF_FFFF;
    localparam int          MAX_SHOWN  = 10;

    typedef struct packed {
        logic [31:0] distance;
        logic        last;
    } t_dist_req;

    // predicts the distances of each line and holds them until they come out
    class envelope_scoreboard;
        logic [31:0] heights [LINE_CAP];
        logic [5:0]  vertex [LINE_CAP];
        longint      bnd_num [LINE_CAP+1];
        longint      bnd_den [LINE_CAP+1];
        int          top;
        int          fill;
        t_dist_req   expected_dist [$];
        int          errors;
        int          compared;
        int          samples;
        int          lines;

        function new();
            top      = 0;
            fill     = 0;
            errors   = 0;
            compared = 0;
            samples  = 0;
            lines    = 0;
        endfunction

        function int outstanding();
            return expected_dist.size();
        endfunction

        // crossing point of the parabolas rooted at q and v, q > v
        function void parabola_cross(int q, int v, output longint num, output longint den);
            longint fq;
            longint fv;
            bit     iq;
            bit     iv;
            fq = heights[q];
            fv = heights[v];
            iq = (heights[q] == HEIGHT_INF);
            iv = (heights[v] == HEIGHT_INF);
            den = 2 * (q - v);
            if (iq && iv) begin
                num = 0;
            end else if (iq) begin
                num = longint'(INF_NUM);
                den = 1;
            end else if (iv) begin
                num = longint'(NEG_INF_NUM);
                den = 1;
            end else begin
                num = (fq + longint'(q * q)) - (fv + longint'(v * v));
            end
        endfunction

        function void emit_distances(int n);
            int        k;
            int        v;
            longint    d;
            longint    fv;
            longint    r;
            t_dist_req e;
            k = 0;
            for (int p = 0; p < n; p++) begin
                while (k < top && bnd_num[k+1] < longint'(p) * bnd_den[k+1])
                    k++;
                v  = vertex[k];
                fv = heights[v];
                d  = (p >= v) ? p - v : v - p;
                if (heights[v] == HEIGHT_INF) begin
                    r = fv;
                end else begin
                    r = d * d + fv;
                    if (r > longint'(HEIGHT_INF))
                        r = longint'(HEIGHT_INF);
                end
                e.distance = r[31:0];
                e.last     = (p + 1 == n);
                expected_dist.push_back(e);
            end
        endfunction

        function void add_sample(logic [31:0] h, logic line_end);
            int     q;
            int     k;
            int     n;
            longint num;
            longint den;
            q = fill;
            if (q >= LINE_CAP)
                q = 0;
            heights[q] = h;
            samples++;
            if (q == 0) begin
                vertex[0]  = '0;
                bnd_num[0] = longint'(NEG_INF_NUM);
                bnd_den[0] = 1;
                bnd_num[1] = longint'(INF_NUM);
                bnd_den[1] = 1;
                top        = 0;
            end else begin
                k = top;
                parabola_cross(q, vertex[k], num, den);
                // pop while the new crossing lies at or left of the top boundary
                while (k > 0 && num * bnd_den[k] <= bnd_num[k] * den) begin
                    k--;
                    parabola_cross(q, vertex[k], num, den);
                end
                k++;
                vertex[k]    = q[5:0];
                bnd_num[k]   = num;
                bnd_den[k]   = den;
                bnd_num[k+1] = longint'(INF_NUM);
                bnd_den[k+1] = 1;
                top          = k;
            end
            n    = q + 1;
            fill = n;
            // a full line closes even without line_end
            if (line_end || n >= LINE_CAP) begin
                emit_distances(n);
                lines++;
                fill = 0;
                top  = 0;
            end
        endfunction

        function void check_distance(logic [31:0] distance, logic last);
            t_dist_req e;
            if (expected_dist.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("tb: unexpected distance %h run_end %b", distance, last);
                return;
            end
            e = expected_dist.pop_front();
            compared++;
            if (e.distance !== distance || e.last !== last) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("tb: mismatch at %0t: expected %h/%b got %h/%b",
                             $realtime, e.distance, e.last, distance, last);
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic sink_ready = 1'b0;
    int   idle_pct  = 0;
    int   stall_pct = 0;

    envelope_scoreboard sb;

    pedt_in_if  in_ch ();
    pedt_out_if out_ch ();

    assign out_ch.ready = sink_ready;

    parabola_envelope_distance_transform_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side: check accepted distances and stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && sink_ready)
            sb.check_distance(out_ch.distance_sq, out_ch.run_end);
        sink_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_sample(input logic [31:0] h, input logic line_end);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.height   <= h;
        in_ch.line_end <= line_end;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        sb.add_sample(h, line_end);
    endtask

    task automatic send_line_of(input logic [31:0] hs [$]);
        foreach (hs[i])
            send_sample(hs[i], i == hs.size() - 1);
    endtask

    // hold the sender off until every predicted distance has come out
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.outstanding() != 0);
    endtask

    function automatic logic [31:0] pick_height(int style);
        logic [31:0] h;
        case (style)
            0:       h = $urandom_range(15);
            1:       h = $urandom_range(4095);
            3:       h = HEIGHT_INF - $urandom_range(1, 5000);
            default: h = $urandom;
        endcase
        if ($urandom_range(99) < ((style == 4) ? 45 : 6))
            h = HEIGHT_INF;
        return h;
    endfunction

    task automatic send_random_line();
        int roll;
        int len;
        int style;
        roll  = $urandom_range(99);
        style = $urandom_range(4);
        if (roll < 67)
            len = $urandom_range(1, 10);
        else if (roll < 87)
            len = $urandom_range(11, 40);
        else if (roll < 94)
            len = LINE_CAP;
        else
            len = $urandom_range(LINE_CAP + 1, 90);   // runs past a full line
        for (int i = 0; i < len; i++)
            send_sample(pick_height(style), i == len - 1);
    endtask

    initial begin
        int phase_start;
        sb = new();
        in_ch.valid    <= 1'b0;
        in_ch.height   <= '0;
        in_ch.line_end <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed lines: single samples, infinities, saturation, ties, pops
        send_line_of('{32'd0});
        send_line_of('{HEIGHT_INF});
        send_line_of('{HEIGHT_INF, HEIGHT_INF, 32'd5});
        send_line_of('{32'd7, HEIGHT_INF, 32'hFFFF_FFFE});
        send_line_of('{32'hFFFF_FFFE, 32'd0, 32'hFFFF_FFFE, 32'hFFFF_FFF0});
        send_line_of('{32'd3, 32'd3, 32'd3, 32'd3});
        send_line_of('{32'd0, 32'd100, 32'd50, 32'd0, 32'd9, 32'd1});
        drain_results();

        // four idling modes, draining between them
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 57; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 57; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            phase_start = sb.samples;
            while (sb.samples - phase_start < 125)
                send_random_line();
            drain_results();
        end

        repeat (200) @(posedge i_clk);
        $display("summary: %0d samples over %0d lines, %0d distances compared",
                 sb.samples, sb.lines, sb.compared);
        $display("summary: %0d mismatches, %0d distances still expected",
                 sb.errors, sb.outstanding());
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
